// File: sv/spq_pkg.sv
// spq_pkg: shared types and codes for the sorted priority queue
// holds the transaction structs, command and status codes, cell control struct
// no dependencies
`default_nettype none

package spq_pkg;

  // command codes
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  // status codes
  localparam logic [1:0] ST_INSERTED  = 2'd0;
  localparam logic [1:0] ST_REMOVED   = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;
  localparam logic [1:0] ST_OVERFLOW  = 2'd3;

  // value reported on a remove from an empty queue, and on inserts
  localparam logic signed [31:0] VALUE_EMPTY = -32'sd1;
  localparam logic signed [31:0] VALUE_NONE  = 32'sd0;

  // input transaction
  typedef struct packed {
    logic               command;
    logic signed [31:0] value_in;
    logic [15:0]        priority_in;
  } in_t;

  // result transaction
  typedef struct packed {
    logic signed [31:0] value_out;
    logic [1:0]         status;
    logic [4:0]         occupancy;
  } out_t;

  // per-cell control from the top level
  typedef struct packed {
    logic ins;       // insert taken this cycle
    logic rem;       // remove taken this cycle
    logic occupied;  // cell index below the entry count
    logic at_tail;   // cell index equals the entry count
  } cell_ctl_t;

endpackage

`default_nettype wire

// File: sv/spq_cell.sv
// spq_cell: one slot of the sorted row, holds a value and its priority
// shifts toward the tail on insert and toward the head on remove
// depends on spq_pkg
`default_nettype none

module spq_cell #(
  parameter int PRIORITY_BITS = 16
) (
  input  wire                      clk,
  input  spq_pkg::cell_ctl_t       ctl,
  input  wire  [31:0]              new_value,
  input  wire  [PRIORITY_BITS-1:0] new_prio,
  input  wire  [31:0]              prev_value,
  input  wire  [PRIORITY_BITS-1:0] prev_prio,
  input  wire                      prev_ge,
  input  wire  [31:0]              next_value,
  input  wire  [PRIORITY_BITS-1:0] next_prio,
  output logic [31:0]              value,
  output logic [PRIORITY_BITS-1:0] prio,
  output logic                     ge
);

  logic [31:0]              value_r, value_nxt;
  logic [PRIORITY_BITS-1:0] prio_r, prio_nxt;

  // held entry goes behind the new one when its priority is equal or greater
  assign ge = ctl.occupied && (prio_r >= new_prio);

  // slot update: take the neighbor ahead, the new entry, or the one behind
  always_comb begin
    value_nxt = value_r;
    prio_nxt  = prio_r;
    if (ctl.ins) begin
      if (prev_ge) begin
        value_nxt = prev_value;
        prio_nxt  = prev_prio;
      end else if (ge || ctl.at_tail) begin
        value_nxt = new_value;
        prio_nxt  = new_prio;
      end
    end else if (ctl.rem) begin
      value_nxt = next_value;
      prio_nxt  = next_prio;
    end
  end

  // payload storage, no reset
  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    prio_r  <= prio_nxt;
  end

  assign value = value_r;
  assign prio  = prio_r;

endmodule

`default_nettype wire

// File: sv/sorted_priority_queue.sv
// sorted_priority_queue: bounded priority queue kept as a sorted row of cells
// top level with command decode, entry count and result register
// depends on spq_pkg and spq_cell
//
//   channel   ports                      direction  handshake
//   input     start, busy, in_item       in         accepted when start && !busy
//   result    out_valid, out_item        out        one-cycle strobe, no back-pressure
//
// one transaction is accepted every cycle; busy stays low
// the result appears on the cycle after acceptance, for one cycle
// each cell does one priority compare per cycle, which sets the clock path
// synchronous active-low reset clears the entry count and the result strobe
// the receiver cannot stall, so nothing is held back
`default_nettype none

module sorted_priority_queue #(
  parameter int CAPACITY      = 16,
  parameter int PRIORITY_BITS = 16
) (
  input  wire           clk,
  input  wire           rst_n,
  input  wire           start,
  output logic          busy,
  input  spq_pkg::in_t  in_item,
  output logic          out_valid,
  output spq_pkg::out_t out_item
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0]         count_r, count_nxt;
  logic                     out_valid_r;
  spq_pkg::out_t            out_item_r, out_item_nxt;
  logic                     accept, full, empty, do_ins, do_rem;
  logic [47:0]              prio_ext;
  logic [PRIORITY_BITS-1:0] new_prio;
  logic [CNT_W+4:0]         occ_ext;

  logic [31:0]              cval [CAPACITY];
  logic [PRIORITY_BITS-1:0] cpri [CAPACITY];
  logic                     cge  [CAPACITY];

  // never stalls
  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign full   = (count_r == CNT_W'(CAPACITY));
  assign empty  = (count_r == '0);
  assign do_ins = accept && (in_item.command == spq_pkg::CMD_INSERT) && !full;
  assign do_rem = accept && (in_item.command == spq_pkg::CMD_REMOVE) && !empty;

  // priority trimmed or zero-extended to the stored width
  assign prio_ext = {32'd0, in_item.priority_in};
  assign new_prio = prio_ext[PRIORITY_BITS-1:0];

  // row of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
    spq_pkg::cell_ctl_t       ctl;
    logic [31:0]              pv, nv;
    logic [PRIORITY_BITS-1:0] pp, np;
    logic                     pg;

    assign ctl.ins      = do_ins;
    assign ctl.rem      = do_rem;
    assign ctl.occupied = (IDX < count_r);
    assign ctl.at_tail  = (IDX == count_r);

    if (i == 0) begin : g_head
      assign pv = in_item.value_in;
      assign pp = new_prio;
      assign pg = 1'b0;
    end else begin : g_body
      assign pv = cval[i-1];
      assign pp = cpri[i-1];
      assign pg = cge[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign nv = cval[i];
      assign np = cpri[i];
    end else begin : g_inner
      assign nv = cval[i+1];
      assign np = cpri[i+1];
    end

    spq_cell #(
      .PRIORITY_BITS(PRIORITY_BITS)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .new_value (in_item.value_in),
      .new_prio  (new_prio),
      .prev_value(pv),
      .prev_prio (pp),
      .prev_ge   (pg),
      .next_value(nv),
      .next_prio (np),
      .value     (cval[i]),
      .prio      (cpri[i]),
      .ge        (cge[i])
    );
  end

  // entry count update
  always_comb begin
    count_nxt = count_r;
    if (do_ins) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_rem) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  assign occ_ext = {5'd0, count_nxt};

  // result of the accepted transaction
  always_comb begin
    out_item_nxt.value_out = spq_pkg::VALUE_NONE;
    out_item_nxt.status    = spq_pkg::ST_INSERTED;
    out_item_nxt.occupancy = occ_ext[4:0];
    case (in_item.command)
      spq_pkg::CMD_INSERT: begin
        out_item_nxt.status = full ? spq_pkg::ST_OVERFLOW : spq_pkg::ST_INSERTED;
      end
      spq_pkg::CMD_REMOVE: begin
        if (empty) begin
          out_item_nxt.value_out = spq_pkg::VALUE_EMPTY;
          out_item_nxt.status    = spq_pkg::ST_UNDERFLOW;
        end else begin
          out_item_nxt.value_out = cval[0];
          out_item_nxt.status    = spq_pkg::ST_REMOVED;
        end
      end
      default: begin
        out_item_nxt.status = spq_pkg::ST_INSERTED;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= accept;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

// File: sv/spq_check.sv
// spq_check: port-level checks for the sorted priority queue
// bound to the top level; depends on spq_pkg
`default_nettype none

module spq_check #(
  parameter int CAPACITY = 16
) (
  input wire           clk,
  input wire           rst_n,
  input wire           start,
  input wire           busy,
  input spq_pkg::in_t  in_item,
  input wire           out_valid,
  input spq_pkg::out_t out_item
);

  // every accepted transaction gives a result in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && start && !busy) |=> out_valid)
    else $error("accepted transaction gave no result");

  // an accepted remove reports either a removed entry or an empty queue
  a_remove_status: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_item.command == spq_pkg::CMD_REMOVE) |=>
      (out_item.status == spq_pkg::ST_REMOVED || out_item.status == spq_pkg::ST_UNDERFLOW))
    else $error("remove gave an insert status");

  // underflow reports an empty queue and the all-ones value
  a_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status == spq_pkg::ST_UNDERFLOW) |->
      (out_item.occupancy == 5'd0 && out_item.value_out == spq_pkg::VALUE_EMPTY))
    else $error("underflow result inconsistent");

  // overflow only at full capacity, with a zero value
  a_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status == spq_pkg::ST_OVERFLOW) |->
      (out_item.occupancy == 5'(CAPACITY) && out_item.value_out == spq_pkg::VALUE_NONE))
    else $error("overflow result inconsistent");

  // back-to-back insert grows occupancy by one
  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(out_valid) && out_item.status == spq_pkg::ST_INSERTED) |->
      (out_item.occupancy == 5'($past(out_item.occupancy) + 5'd1)))
    else $error("insert did not grow occupancy by one");

endmodule

bind sorted_priority_queue spq_check #(
  .CAPACITY(CAPACITY)
) u_spq_check (
  .clk      (clk),
  .rst_n    (rst_n),
  .start    (start),
  .busy     (busy),
  .in_item  (in_item),
  .out_valid(out_valid),
  .out_item (out_item)
);

`default_nettype wire

// File: tb/sorted_priority_queue_tb.sv
// sorted_priority_queue_tb: self-checking testbench for the sorted priority queue
// drives command transactions, predicts each result from a shadow sorted list
// depends on spq_pkg and sorted_priority_queue
`timescale 1ns / 100ps

module sorted_priority_queue_tb;

  localparam int CAPACITY      = 16;
  localparam int PRIORITY_BITS = 16;
  localparam logic [15:0] PRIO_MASK = 16'((32'h1 << PRIORITY_BITS) - 1);
  localparam int CYCLE_LIMIT   = 200000;
  localparam int IDLE_PCT      = 27;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  spq_pkg::in_t  in_item = '0;
  logic busy;
  logic out_valid;
  spq_pkg::out_t out_item;

  // shadow copy of the queue contents, front at index 0
  logic signed [31:0] held_value [CAPACITY];
  logic [15:0]        held_prio [CAPACITY];
  int                 held_count = 0;

  spq_pkg::out_t pending_results [$];
  int   error_count = 0;
  int   cycle_count = 0;

  sorted_priority_queue #(
    .CAPACITY(CAPACITY),
    .PRIORITY_BITS(PRIORITY_BITS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_item(out_item)
  );

  always #1 clk = ~clk;

  // watchdog on total run length
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t timeout with %0d results outstanding", $time, pending_results.size());
      $display("sorted_priority_queue_tb: FAIL");
      $finish;
    end
  end

  // apply one command to the shadow list and return the result it should give
  function automatic spq_pkg::out_t sorted_queue_step(input spq_pkg::in_t item);
    spq_pkg::out_t res;
    int            pos;
    int            k;
    logic [15:0]   pri;
    res.value_out = spq_pkg::VALUE_NONE;
    pri = item.priority_in & PRIO_MASK;
    if (item.command == spq_pkg::CMD_INSERT) begin
      if (held_count >= CAPACITY) begin
        res.status = spq_pkg::ST_OVERFLOW;
      end else begin
        // new entry goes ahead of every equal or larger priority
        pos = 0;
        while (pos < held_count && held_prio[pos] < pri) pos++;
        for (k = held_count; k > pos; k--) begin
          held_value[k] = held_value[k-1];
          held_prio[k]  = held_prio[k-1];
        end
        held_value[pos] = item.value_in;
        held_prio[pos]  = pri;
        held_count++;
        res.status = spq_pkg::ST_INSERTED;
      end
    end else if (held_count == 0) begin
      res.value_out = spq_pkg::VALUE_EMPTY;
      res.status    = spq_pkg::ST_UNDERFLOW;
    end else begin
      res.value_out = held_value[0];
      for (k = 1; k < held_count; k++) begin
        held_value[k-1] = held_value[k];
        held_prio[k-1]  = held_prio[k];
      end
      held_count--;
      res.status = spq_pkg::ST_REMOVED;
    end
    res.occupancy = 5'(held_count);
    return res;
  endfunction

  function automatic spq_pkg::in_t make_cmd(input logic cmd, input logic [31:0] val,
                                            input logic [15:0] pri);
    spq_pkg::in_t it;
    it.command     = cmd;
    it.value_in    = val;
    it.priority_in = pri;
    return it;
  endfunction

  // random command; priorities lean toward a narrow band so ties are common
  function automatic spq_pkg::in_t random_cmd(input int insert_pct);
    spq_pkg::in_t it;
    int           sel;
    it.command  = ($urandom_range(0, 99) < insert_pct) ? spq_pkg::CMD_INSERT
                                                       : spq_pkg::CMD_REMOVE;
    it.value_in = $urandom;
    sel = $urandom_range(0, 9);
    if (sel < 5)       it.priority_in = 16'($urandom_range(0, 7));
    else if (sel == 5) it.priority_in = 16'hffff;
    else if (sel == 6) it.priority_in = 16'h0000;
    else               it.priority_in = 16'($urandom_range(0, 65535));
    return it;
  endfunction

  // hold one transaction on the input until the block takes it
  task automatic send_cmd(input spq_pkg::in_t item);
    start   <= 1'b1;
    in_item <= item;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(sorted_queue_step(item));
  endtask

  // random idle cycles with junk on the data lines
  task automatic idle_gap();
    while ($urandom_range(0, 99) < IDLE_PCT) begin
      start   <= 1'b0;
      in_item <= random_cmd(50);
      @(posedge clk);
    end
  endtask

  // result checker: every strobe must match the oldest expectation
  always @(posedge clk) begin
    spq_pkg::out_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result: value %0d status %0d occupancy %0d",
                 $time, out_item.value_out, out_item.status, out_item.occupancy);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_item.value_out !== want.value_out) begin
          $display("%0t value_out mismatch: expected %0d actual %0d",
                   $time, want.value_out, out_item.value_out);
          error_count++;
        end
        if (out_item.status !== want.status) begin
          $display("%0t status mismatch: expected %0d actual %0d",
                   $time, want.status, out_item.status);
          error_count++;
        end
        if (out_item.occupancy !== want.occupancy) begin
          $display("%0t occupancy mismatch: expected %0d actual %0d",
                   $time, want.occupancy, out_item.occupancy);
          error_count++;
        end
      end
    end
  end

  // remove on an empty queue
  task automatic test_underflow();
    send_cmd(make_cmd(spq_pkg::CMD_REMOVE, 32'h0, 16'h0));
    send_cmd(make_cmd(spq_pkg::CMD_REMOVE, 32'hffffffff, 16'hffff));
  endtask

  // largest and smallest values and priorities
  task automatic test_extreme_fields();
    send_cmd(make_cmd(spq_pkg::CMD_INSERT, 32'h7fffffff, 16'hffff));
    send_cmd(make_cmd(spq_pkg::CMD_INSERT, 32'h80000000, 16'h0000));
    send_cmd(make_cmd(spq_pkg::CMD_INSERT, 32'hffffffff, 16'h8000));
    send_cmd(make_cmd(spq_pkg::CMD_INSERT, 32'h00000000, 16'h0001));
    send_cmd(make_cmd(spq_pkg::CMD_REMOVE, 32'h0, 16'h0));
    send_cmd(make_cmd(spq_pkg::CMD_REMOVE, 32'h0, 16'h0));
  endtask

  // equal priorities come out last-in first-out
  task automatic test_equal_priority();
    send_cmd(make_cmd(spq_pkg::CMD_INSERT, 32'd11, 16'h8000));
    send_cmd(make_cmd(spq_pkg::CMD_INSERT, 32'd22, 16'h8000));
    send_cmd(make_cmd(spq_pkg::CMD_INSERT, 32'd33, 16'h8000));
    send_cmd(make_cmd(spq_pkg::CMD_REMOVE, 32'h0, 16'h0));
    send_cmd(make_cmd(spq_pkg::CMD_REMOVE, 32'h0, 16'h0));
  endtask

  // fill to capacity, then inserts are refused
  task automatic test_fill_overflow();
    int n;
    n = 0;
    while (held_count < CAPACITY) begin
      send_cmd(make_cmd(spq_pkg::CMD_INSERT, 32'h5a5a0000 + n,
                        (n % 2) ? 16'h5555 : 16'haaaa));
      n++;
    end
    send_cmd(make_cmd(spq_pkg::CMD_INSERT, 32'h12345678, 16'h0000));
    send_cmd(make_cmd(spq_pkg::CMD_INSERT, 32'h87654321, 16'hffff));
    send_cmd(make_cmd(spq_pkg::CMD_REMOVE, 32'h0, 16'h0));
  endtask

  // random traffic; the insert bias swings so the queue fills and drains often
  task automatic test_random_traffic(input int count, input bit with_gaps);
    int i;
    int insert_pct;
    insert_pct = 50;
    for (i = 0; i < count; i++) begin
      if (i % 40 == 0) begin
        case ($urandom_range(0, 3))
          0: insert_pct = 90;
          1: insert_pct = 10;
          2: insert_pct = 65;
          default: insert_pct = 35;
        endcase
      end
      if (with_gaps) idle_gap();
      send_cmd(random_cmd(insert_pct));
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_underflow();
    test_extreme_fields();
    test_equal_priority();
    test_fill_overflow();
    test_random_traffic(700, 1'b1);
    test_random_traffic(450, 1'b0);
    test_random_traffic(700, 1'b1);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (error_count == 0) begin
      $display("sorted_priority_queue_tb: PASS");
    end else begin
      $display("sorted_priority_queue_tb: FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/spq_pkg.sv
sv/spq_cell.sv
sv/sorted_priority_queue.sv
sv/spq_check.sv
tb/sorted_priority_queue_tb.sv
